>>> sv/shelf_atlas_allocator_defines.svh
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_defines.svh
// Assertion macros shared by the shelf atlas allocator RTL
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_ALLOCATOR_DEFINES_SVH
`define SHELF_ATLAS_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SAA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// Types, constants and helpers for the shelf atlas allocator
// ----------------------------------------------------------------------------
package saa_pkg;

  // number of atlas pages and the widths that follow from it
  localparam int MAX_PAGES = 8;
  localparam int PAGE_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);

  // fixed field widths
  localparam int SIDE_W  = 10;
  localparam int CELL_W  = 7;
  localparam int SIZE_W  = 17;
  localparam int POS_W   = 16;
  localparam int PIDX_W  = 3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ROWS    = 1'b1;
  localparam logic [CELL_W-1:0]    CELLS_RESET       = 7'd16;
  localparam logic [CELL_W-1:0]    CELLS_MAX         = 7'd64;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SIDE_W-1:0] rect_width;
    logic [SIDE_W-1:0] rect_height;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [PIDX_W-1:0] page_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              new_page;
    logic [SIZE_W-1:0] page_width;
    logic [SIZE_W-1:0] page_height;
  } out_word_t;

  // cell count clamped to the usable range
  function automatic logic [CELL_W-1:0] cells(input logic [CELL_W-1:0] r);
    logic [CELL_W-1:0] c;
    c = r;
    if (r == '0) c = CELL_W'(1);
    else if (r > CELLS_MAX) c = CELLS_MAX;
    return c;
  endfunction

endpackage

>>> sv/shelf_atlas_allocator.sv
// ----------------------------------------------------------------------------
// shelf_atlas_allocator
// Shelf packing of glyph rectangles into atlas pages, first-fit over pages,
// with the page size fixed lazily by the first allocation after a clear
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   in_word   (cmd, rect_width, rect_height)
//   out      out  out_valid/out_stall out_word  (ok, page_index, pos, size)
//   cfg      in   cfg_write           cfg_index, cfg_data
//
// A clear goes straight to the output; an allocation checks its size once the
// page size is known, tries the current shelf and then a new shelf on each open
// page in turn, and opens a page if none fits, the first one sizing the atlas
// (a multiply and a doubling search per side). Input stalls until the word is
// done and the output register is free. Synchronous reset; tables need no clearing.
// ----------------------------------------------------------------------------
`include "shelf_atlas_allocator_defines.svh"

module shelf_atlas_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  saa_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output saa_pkg::out_word_t                  out_word,
  input  logic                                cfg_write,
  input  logic [saa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [saa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_OVR_W, S_OVR_H, S_PG_LOAD, S_FIT_X, S_FIT_Y, S_NEW_Y, S_NEW_H,
    S_NEW_PAGE, S_SZ_MUL, S_SZ_POW, S_OPEN, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [saa_pkg::CELL_W-1:0] cache_columns;
  logic [saa_pkg::CELL_W-1:0] cache_rows;

  // atlas state
  logic [saa_pkg::CNT_W-1:0]  pages_used;
  logic                       size_known;
  logic [saa_pkg::SIZE_W-1:0] atlas_width;
  logic [saa_pkg::SIZE_W-1:0] atlas_height;

  // per-page shelf tables
  logic [saa_pkg::SIZE_W-1:0] shelf_cursor_x [saa_pkg::MAX_PAGES];
  logic [saa_pkg::SIZE_W-1:0] shelf_top_y    [saa_pkg::MAX_PAGES];
  logic [saa_pkg::SIDE_W-1:0] shelf_tallest  [saa_pkg::MAX_PAGES];

  // working registers
  logic [saa_pkg::SIDE_W-1:0] rw;
  logic [saa_pkg::SIDE_W-1:0] rh;
  logic [saa_pkg::CNT_W-1:0]  page;
  logic [saa_pkg::SIZE_W-1:0] cx;
  logic [saa_pkg::SIZE_W-1:0] cy;
  logic [saa_pkg::SIDE_W-1:0] mh;
  logic [saa_pkg::SIZE_W-1:0] acc;
  logic                       fit_x;
  logic [saa_pkg::SIZE_W-1:0] prod;
  logic [saa_pkg::SIZE_W-1:0] pw;
  logic                       sz_row;

  // result registers
  logic                       res_ok;
  logic [saa_pkg::PIDX_W-1:0] res_page;
  logic [saa_pkg::POS_W-1:0]  res_x;
  logic [saa_pkg::POS_W-1:0]  res_y;
  logic                       res_new;

  // shared add/compare unit
  logic [saa_pkg::SIZE_W-1:0] unit_a;
  logic [saa_pkg::SIZE_W-1:0] unit_b;
  logic [saa_pkg::SIZE_W-1:0] unit_lim;
  logic [saa_pkg::SIZE_W:0]   unit_sum;
  logic                       unit_le;

  // table write port
  logic                       shelf_we;
  logic [saa_pkg::PAGE_W-1:0] shelf_wa;
  logic [saa_pkg::SIZE_W-1:0] shelf_wx;
  logic [saa_pkg::SIZE_W-1:0] shelf_wy;
  logic [saa_pkg::SIDE_W-1:0] shelf_wt;

  // sizing multiplier and input clean-up
  logic [saa_pkg::SIDE_W-1:0] side;
  logic [saa_pkg::CELL_W-1:0] mul_cells;
  logic [saa_pkg::SIZE_W-1:0] prod_next;
  logic [saa_pkg::SIDE_W-1:0] in_rw;
  logic [saa_pkg::SIDE_W-1:0] in_rh;
  logic [saa_pkg::PAGE_W-1:0] page_idx;
  logic                       in_take;
  logic                       out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign page_idx = page[saa_pkg::PAGE_W-1:0];

  // zero-sized sides count as one texel
  assign in_rw = (in_word.rect_width  == '0) ? saa_pkg::SIDE_W'(1) : in_word.rect_width;
  assign in_rh = (in_word.rect_height == '0) ? saa_pkg::SIDE_W'(1) : in_word.rect_height;

  // cells times the larger side, one side of the page per pass
  assign side      = (rw > rh) ? rw : rh;
  assign mul_cells = sz_row ? saa_pkg::cells(cache_rows) : saa_pkg::cells(cache_columns);
  assign prod_next = saa_pkg::SIZE_W'({{(saa_pkg::SIZE_W-saa_pkg::CELL_W){1'b0}}, mul_cells}
                   * {{(saa_pkg::SIZE_W-saa_pkg::SIDE_W){1'b0}}, side});

  // operand selection for the shared unit
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_lim = '0;
    unique case (state)
      S_OVR_W: begin
        unit_a   = saa_pkg::SIZE_W'(rw);
        unit_lim = atlas_width;
      end
      S_OVR_H: begin
        unit_a   = saa_pkg::SIZE_W'(rh);
        unit_lim = atlas_height;
      end
      S_FIT_X: begin
        unit_a   = cx;
        unit_b   = saa_pkg::SIZE_W'(rw);
        unit_lim = atlas_width;
      end
      S_FIT_Y: begin
        unit_a   = cy;
        unit_b   = saa_pkg::SIZE_W'(rh);
        unit_lim = atlas_height;
      end
      S_NEW_Y: begin
        unit_a   = cy;
        unit_b   = saa_pkg::SIZE_W'(mh);
      end
      S_NEW_H: begin
        unit_a   = acc;
        unit_b   = saa_pkg::SIZE_W'(rh);
        unit_lim = atlas_height;
      end
      S_SZ_POW: begin
        unit_a   = prod;
        unit_lim = pw;
      end
      default: begin
        unit_a   = '0;
      end
    endcase
  end

  assign unit_sum = {1'b0, unit_a} + {1'b0, unit_b};
  assign unit_le  = (unit_sum <= {1'b0, unit_lim});

  // table updates: same shelf, new shelf, or a freshly opened page
  always_comb begin
    shelf_we = 1'b0;
    shelf_wa = page_idx;
    shelf_wx = acc;
    shelf_wy = cy;
    shelf_wt = (rh > mh) ? rh : mh;
    priority if (state == S_FIT_Y && fit_x && unit_le) begin
      shelf_we = 1'b1;
    end else if (state == S_NEW_H && unit_le) begin
      shelf_we = 1'b1;
      shelf_wx = saa_pkg::SIZE_W'(rw);
      shelf_wy = acc;
      shelf_wt = rh;
    end else if (state == S_OPEN) begin
      shelf_we = 1'b1;
      shelf_wa = pages_used[saa_pkg::PAGE_W-1:0];
      shelf_wx = saa_pkg::SIZE_W'(rw);
      shelf_wy = '0;
      shelf_wt = rh;
    end else begin
      shelf_we = 1'b0;
    end
  end

  // page tables
  always_ff @(posedge clk) begin
    if (shelf_we) begin
      shelf_cursor_x[shelf_wa] <= shelf_wx;
      shelf_top_y[shelf_wa]    <= shelf_wy;
      shelf_tallest[shelf_wa]  <= shelf_wt;
    end
    if (state == S_PG_LOAD) begin
      cx <= shelf_cursor_x[page_idx];
      cy <= shelf_top_y[page_idx];
      mh <= shelf_tallest[page_idx];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_columns <= saa_pkg::CELLS_RESET;
      cache_rows    <= saa_pkg::CELLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        saa_pkg::REG_CACHE_COLUMNS: cache_columns <= cfg_data;
        saa_pkg::REG_CACHE_ROWS:    cache_rows    <= cfg_data;
        default:                    cache_rows    <= cache_rows;
      endcase
    end
  end

  // sequencer, atlas state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      pages_used   <= '0;
      size_known   <= 1'b0;
      atlas_width  <= '0;
      atlas_height <= '0;
    end else begin
      // output word leaves; a word finishing this cycle takes its place
      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            rw       <= in_rw;
            rh       <= in_rh;
            page     <= '0;
            sz_row   <= 1'b0;
            res_ok   <= 1'b1;
            res_page <= '0;
            res_x    <= '0;
            res_y    <= '0;
            res_new  <= 1'b0;
            if (in_word.cmd == saa_pkg::CMD_CLEAR) begin
              pages_used   <= '0;
              size_known   <= 1'b0;
              atlas_width  <= '0;
              atlas_height <= '0;
              state        <= S_FINISH;
            end else if (size_known) begin
              state <= S_OVR_W;
            end else begin
              state <= S_PG_LOAD;
            end
          end
        end

        // oversize check against the known page size
        S_OVR_W: begin
          if (unit_le) begin
            state <= S_OVR_H;
          end else begin
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end
        end
        S_OVR_H: begin
          if (unit_le) begin
            state <= S_PG_LOAD;
          end else begin
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end
        end

        // first-fit walk over open pages
        S_PG_LOAD: begin
          if (page == pages_used) state <= S_NEW_PAGE;
          else                    state <= S_FIT_X;
        end
        S_FIT_X: begin
          fit_x <= unit_le;
          acc   <= unit_sum[saa_pkg::SIZE_W-1:0];
          state <= S_FIT_Y;
        end
        S_FIT_Y: begin
          if (fit_x && unit_le) begin
            res_page <= page[saa_pkg::PIDX_W-1:0];
            res_x    <= cx[saa_pkg::POS_W-1:0];
            res_y    <= cy[saa_pkg::POS_W-1:0];
            state    <= S_FINISH;
          end else begin
            state <= S_NEW_Y;
          end
        end
        S_NEW_Y: begin
          acc   <= unit_sum[saa_pkg::SIZE_W-1:0];
          state <= S_NEW_H;
        end
        S_NEW_H: begin
          if (unit_le) begin
            res_page <= page[saa_pkg::PIDX_W-1:0];
            res_y    <= acc[saa_pkg::POS_W-1:0];
            state    <= S_FINISH;
          end else begin
            page  <= page + saa_pkg::CNT_W'(1);
            state <= S_PG_LOAD;
          end
        end

        // no page took it: open another if allowed
        S_NEW_PAGE: begin
          if (pages_used == saa_pkg::CNT_W'(saa_pkg::MAX_PAGES)) begin
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end else if (!size_known) begin
            state <= S_SZ_MUL;
          end else begin
            state <= S_OPEN;
          end
        end

        // page size: next power of two of cells times side
        S_SZ_MUL: begin
          prod  <= prod_next;
          pw    <= saa_pkg::SIZE_W'(1);
          state <= S_SZ_POW;
        end
        S_SZ_POW: begin
          if (unit_le) begin
            if (!sz_row) begin
              atlas_width <= pw;
              sz_row      <= 1'b1;
              state       <= S_SZ_MUL;
            end else begin
              atlas_height <= pw;
              size_known   <= 1'b1;
              state        <= S_OPEN;
            end
          end else begin
            pw <= {pw[saa_pkg::SIZE_W-2:0], 1'b0};
          end
        end

        S_OPEN: begin
          res_page   <= pages_used[saa_pkg::PIDX_W-1:0];
          res_new    <= 1'b1;
          pages_used <= pages_used + saa_pkg::CNT_W'(1);
          state      <= S_FINISH;
        end

        // hand the word to the output register once it is free
        S_FINISH: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_word.ok          <= res_ok;
            out_word.page_index  <= res_ok ? res_page : '0;
            out_word.pos_x       <= res_ok ? res_x : '0;
            out_word.pos_y       <= res_ok ? res_y : '0;
            out_word.new_page    <= res_ok & res_new;
            out_word.page_width  <= atlas_width;
            out_word.page_height <= atlas_height;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SAA_ASSERT_NOW(a_pages_bound, 1'b1, pages_used <= saa_pkg::CNT_W'(saa_pkg::MAX_PAGES), "page count beyond limit")
  `SAA_ASSERT_NOW(a_unsized_empty, !size_known, pages_used == '0 && atlas_height == '0, "pages open without a page size")
  `SAA_ASSERT_NOW(a_new_page_sized, out_valid && out_word.new_page, out_word.page_width != '0 && out_word.page_height != '0, "new page reported with no size")
  `SAA_ASSERT_NEXT(a_clear_empties, in_take && in_word.cmd == saa_pkg::CMD_CLEAR, pages_used == '0 && !size_known, "clear left pages open")
  `SAA_ASSERT_NOW(a_fail_zero, out_valid && !out_word.ok, out_word.pos_x == '0 && out_word.pos_y == '0 && !out_word.new_page, "failure word carries a placement")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shelf atlas allocator. A directed table covers
// clears, the largest and smallest rectangles, oversized rectangles, cell
// counts out of range and a full set of pages. Random runs of clear followed
// by allocations mostly of similar sizes come next, each under its own cell counts.
// Every result word is checked field by field against the expected word of its
// table row where one is typed, else against a shelf-packing predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_WORDS = 500;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 100;

  logic                           clk;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  saa_pkg::in_word_t              in_word   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  saa_pkg::out_word_t             out_word;
  logic                           cfg_write = 1'b0;
  logic [saa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [saa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  shelf_atlas_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // atlas state as the bench sees it
  logic [saa_pkg::CELL_W-1:0] cols_reg = saa_pkg::CELLS_RESET;
  logic [saa_pkg::CELL_W-1:0] rows_reg = saa_pkg::CELLS_RESET;
  int unsigned       n_open   = 0;
  bit                sized    = 1'b0;
  int unsigned       pg_w     = 0;
  int unsigned       pg_h     = 0;
  int unsigned       cur_x [saa_pkg::MAX_PAGES];
  int unsigned       top_y [saa_pkg::MAX_PAGES];
  int unsigned       tall  [saa_pkg::MAX_PAGES];

  saa_pkg::out_word_t placement_q [$];
  saa_pkg::out_word_t due;
  int unsigned words_sent = 0;
  int unsigned words_back = 0;
  int unsigned faults     = 0;
  int unsigned stuck      = 0;
  bit          quiet      = 1'b0;

  // directed table row: optional cell-count write, one word, optional typed result
  typedef struct {
    bit cfg;
    int cols;
    int rows;
    bit cmd;
    int w;
    int h;
    bit typed;
    bit ok;
    int page;
    int x;
    int y;
    bit fresh;
    int pw;
    int ph;
  } drill_t;

  drill_t drill [24] = '{
    // reset cell counts: large first rectangle, then a zero-sized one
    '{0, 0, 0, saa_pkg::CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1023, 1023, 1, 1, 0, 0, 0, 1, 16384, 16384},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // small page, then rectangles too wide and too tall
    '{0, 0, 0, saa_pkg::CMD_CLEAR, 1023, 1023, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1, 1, 1, 1, 0, 0, 0, 1, 16, 16},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 17, 1, 1, 0, 0, 0, 0, 0, 16, 16},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1, 17, 1, 0, 0, 0, 0, 0, 16, 16},
    // cell counts below and above the usable range
    '{1, 0, 127, saa_pkg::CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1, 1, 1, 1, 0, 0, 0, 1, 1, 64},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 2, 1, 1, 0, 0, 0, 0, 0, 1, 64},
    // one rectangle per page until every page is open
    '{1, 1, 1, saa_pkg::CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 5, 3, 1, 1, 0, 0, 0, 1, 8, 8},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 8, 8, 1, 0, 0, 0, 0, 0, 8, 8},
    // largest page size
    '{1, 64, 64, saa_pkg::CMD_CLEAR, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1023, 1, 1, 1, 0, 0, 0, 1, 65536, 65536},
    '{0, 0, 0, saa_pkg::CMD_ALLOC, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // smallest power of two not below v, capped at 65536
  function automatic int unsigned pow2_up(input int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v && p < 32'h10000) p = p << 1;
    return p;
  endfunction

  // shelf placement of one word, updating the atlas state
  function automatic saa_pkg::out_word_t atlas_place(input saa_pkg::in_word_t w);
    saa_pkg::out_word_t r;
    int unsigned rw, rh, side, cc, rc, p;
    r = '0;
    if (w.cmd == saa_pkg::CMD_CLEAR) begin
      n_open = 0;
      sized  = 1'b0;
      pg_w   = 0;
      pg_h   = 0;
      r.ok   = 1'b1;
      return r;
    end
    rw = w.rect_width;
    rh = w.rect_height;
    if (rw == 0) rw = 1;
    if (rh == 0) rh = 1;
    if (!(sized && (rw > pg_w || rh > pg_h))) begin
      // first fit over the open pages
      for (p = 0; p < n_open && !r.ok; p++) begin
        if (cur_x[p] + rw <= pg_w && top_y[p] + rh <= pg_h) begin
          r.ok         = 1'b1;
          r.page_index = p[saa_pkg::PIDX_W-1:0];
          r.pos_x      = cur_x[p][saa_pkg::POS_W-1:0];
          r.pos_y      = top_y[p][saa_pkg::POS_W-1:0];
          cur_x[p]     = cur_x[p] + rw;
          if (rh > tall[p]) tall[p] = rh;
        end else if (top_y[p] + tall[p] + rh <= pg_h) begin
          r.ok         = 1'b1;
          r.page_index = p[saa_pkg::PIDX_W-1:0];
          r.pos_y      = saa_pkg::POS_W'(top_y[p] + tall[p]);
          top_y[p]     = top_y[p] + tall[p];
          cur_x[p]     = rw;
          tall[p]      = rh;
        end
      end
      // open a page, sizing the atlas on the first one
      if (!r.ok && n_open < saa_pkg::MAX_PAGES) begin
        if (!sized) begin
          side = (rw > rh) ? rw : rh;
          cc   = cols_reg;
          rc   = rows_reg;
          if (cc == 0) cc = 1;
          else if (cc > saa_pkg::CELLS_MAX) cc = saa_pkg::CELLS_MAX;
          if (rc == 0) rc = 1;
          else if (rc > saa_pkg::CELLS_MAX) rc = saa_pkg::CELLS_MAX;
          pg_w  = pow2_up(cc * side);
          pg_h  = pow2_up(rc * side);
          sized = 1'b1;
        end
        r.ok         = 1'b1;
        r.page_index = n_open[saa_pkg::PIDX_W-1:0];
        r.new_page   = 1'b1;
        cur_x[n_open] = rw;
        top_y[n_open] = 0;
        tall[n_open]  = rh;
        n_open++;
      end
    end
    r.page_width  = pg_w[saa_pkg::SIZE_W-1:0];
    r.page_height = pg_h[saa_pkg::SIZE_W-1:0];
    return r;
  endfunction

  // mismatch report
  task automatic note_fault(input string msg);
    faults++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) note_fault($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // offer one word, with a random gap first; valid stays high afterwards
  task automatic send_word(input saa_pkg::in_word_t w, input bit typed,
                           input saa_pkg::out_word_t want);
    saa_pkg::out_word_t guess;
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = atlas_place(w);
    if (typed) guess = want;
    placement_q = {placement_q, guess};
    words_sent++;
  endtask

  // hold off until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_back != words_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [saa_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= saa_pkg::CFG_DATA_W'(val);
    if (idx == saa_pkg::REG_CACHE_COLUMNS) cols_reg = val[saa_pkg::CELL_W-1:0];
    else rows_reg = val[saa_pkg::CELL_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // cell count for a random run, leaning towards small pages that fill up
  function automatic int unsigned pick_cells();
    int unsigned roll;
    roll = $urandom_range(9);
    unique case (roll)
      5: return 0;
      6: return saa_pkg::CELLS_MAX;
      7: return 127;
      8: return $urandom_range(5, 127);
      9: return saa_pkg::CELLS_RESET;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // side length scattered around a glyph size
  function automatic logic [saa_pkg::SIDE_W-1:0] jitter_side(input int unsigned base);
    int unsigned s;
    s = base / 2 + $urandom_range(0, base);
    if (s > 1023) s = 1023;
    return saa_pkg::SIDE_W'(s);
  endfunction

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (placement_q.size() == 0) begin
        note_fault("result word with nothing expected");
      end else begin
        due = placement_q.pop_front();
        check_field("ok", out_word.ok, due.ok);
        check_field("page_index", out_word.page_index, due.page_index);
        check_field("pos_x", out_word.pos_x, due.pos_x);
        check_field("pos_y", out_word.pos_y, due.pos_y);
        check_field("new_page", out_word.new_page, due.new_page);
        check_field("page_width", out_word.page_width, due.page_width);
        check_field("page_height", out_word.page_height, due.page_height);
      end
      words_back++;
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 12);
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck <= 0;
      end else if (stuck >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  // stimulus
  initial begin
    saa_pkg::in_word_t  w;
    saa_pkg::out_word_t want;
    int unsigned n, len, base, roll;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (drill[i]) begin
      if (drill[i].cfg) begin
        drain_results();
        write_reg(saa_pkg::REG_CACHE_COLUMNS, drill[i].cols);
        write_reg(saa_pkg::REG_CACHE_ROWS, drill[i].rows);
      end
      w.cmd              = drill[i].cmd;
      w.rect_width       = saa_pkg::SIDE_W'(drill[i].w);
      w.rect_height      = saa_pkg::SIDE_W'(drill[i].h);
      want.ok            = drill[i].ok;
      want.page_index    = saa_pkg::PIDX_W'(drill[i].page);
      want.pos_x         = saa_pkg::POS_W'(drill[i].x);
      want.pos_y         = saa_pkg::POS_W'(drill[i].y);
      want.new_page      = drill[i].fresh;
      want.page_width    = saa_pkg::SIZE_W'(drill[i].pw);
      want.page_height   = saa_pkg::SIZE_W'(drill[i].ph);
      send_word(w, drill[i].typed, want);
    end

    // random runs: new cell counts, a clear, then glyphs of a similar size
    want = '0;
    n = 0;
    while (n < RANDOM_WORDS) begin
      drain_results();
      write_reg(saa_pkg::REG_CACHE_COLUMNS, pick_cells());
      write_reg(saa_pkg::REG_CACHE_ROWS, pick_cells());
      roll = $urandom_range(99);
      if (roll < 50) base = $urandom_range(1, 24);
      else if (roll < 80) base = $urandom_range(25, 160);
      else base = $urandom_range(161, 1023);
      w.cmd         = saa_pkg::CMD_CLEAR;
      w.rect_width  = saa_pkg::SIDE_W'($urandom_range(0, 1023));
      w.rect_height = saa_pkg::SIDE_W'($urandom_range(0, 1023));
      send_word(w, 1'b0, want);
      n++;
      len = $urandom_range(20, 60);
      repeat (len) begin
        // a long stretch with no idling on either side
        quiet = (n >= 200 && n < 320);
        roll  = $urandom_range(99);
        w.cmd = (roll < 5) ? saa_pkg::CMD_CLEAR : saa_pkg::CMD_ALLOC;
        if (roll < 15) begin
          w.rect_width  = saa_pkg::SIDE_W'($urandom_range(0, 1023));
          w.rect_height = saa_pkg::SIDE_W'($urandom_range(0, 1023));
        end else begin
          w.rect_width  = jitter_side(base);
          w.rect_height = jitter_side(base);
        end
        send_word(w, 1'b0, want);
        n++;
      end
    end
    quiet = 1'b0;

    // wind down
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (placement_q.size() != 0) begin
      note_fault($sformatf("%0d result words never arrived", placement_q.size()));
    end
    if (faults == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/saa_pkg.sv
sv/shelf_atlas_allocator.sv
tb/sv/tb_top.sv
